/* src/cid_pkg.sv */
package cid_pkg;

  // Store geometry
  localparam int BufDepth = 524288;
  localparam int AddrW    = $clog2(BufDepth);
  localparam int SizeW    = AddrW + 1;
  localparam int MinSize  = 64;

  // Sample and position formats
  localparam int SampleW  = 24;
  localparam int FracBits = 16;
  localparam int PosW     = 40;
  localparam int IntW     = PosW - FracBits;

  // Remainder unit: one dividend bit per cycle
  localparam int DivW     = IntW;
  localparam int CntW     = $clog2(DivW + 1);

  // Horner datapath widths
  localparam int TW       = 30;
  localparam int ProdW    = TW + FracBits + 1;
  localparam int VW       = TW + 1;

  // Request codes
  localparam logic ReqWrite = 1'b0;
  localparam logic ReqRead  = 1'b1;

  // Configuration register indexes
  localparam logic RegActiveSize = 1'b0;
  localparam logic RegFreeze     = 1'b1;

  typedef struct packed {
    logic             start;
    logic [DivW-1:0]  dividend;
    logic [SizeW-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic               en;
    logic [AddrW-1:0]   addr;
    logic [SampleW-1:0] data;
  } wr_req_t;

  typedef struct packed {
    logic             en;
    logic [AddrW-1:0] addr;
  } rd_req_t;

endpackage

/* src/cid_mod_unit.sv */
module cid_mod_unit (
  input  logic                       clk,
  input  logic                       rst,
  input  cid_pkg::div_req_t          req,
  output logic                       done,
  output logic [cid_pkg::AddrW-1:0]  rem
);

  logic                        running;
  logic [cid_pkg::CntW-1:0]    cnt;
  logic [cid_pkg::DivW-1:0]    dvd;
  logic [cid_pkg::SizeW-1:0]   acc;
  logic [cid_pkg::SizeW-1:0]   dsr;
  logic [cid_pkg::SizeW:0]     shifted;
  logic                        ge;
  logic [cid_pkg::SizeW-1:0]   acc_next;

  // One restoring step: shift in next dividend bit, subtract if it fits
  always_comb begin
    shifted  = {acc, dvd[cid_pkg::DivW-1]};
    ge       = (shifted >= {1'b0, dsr});
    acc_next = ge ? cid_pkg::SizeW'(shifted - {1'b0, dsr})
                  : cid_pkg::SizeW'(shifted);
  end

  // Control
  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      done    <= 1'b0;
      cnt     <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        running <= 1'b1;
        cnt     <= cid_pkg::CntW'(cid_pkg::DivW);
      end else if (running) begin
        cnt <= cnt - cid_pkg::CntW'(1);
        if (cnt == cid_pkg::CntW'(1)) begin
          running <= 1'b0;
          done    <= 1'b1;
        end
      end
    end
  end

  // Datapath
  always_ff @(posedge clk) begin
    if (req.start) begin
      acc <= '0;
      dvd <= req.dividend;
      dsr <= req.divisor;
    end else if (running) begin
      acc <= acc_next;
      dvd <= {dvd[cid_pkg::DivW-2:0], 1'b0};
    end
  end

  // Remainder is below the divisor, which is at most the depth
  assign rem = acc[cid_pkg::AddrW-1:0];

endmodule

/* src/cid_store.sv */
module cid_store (
  input  logic                               clk,
  input  logic                               rst,
  input  cid_pkg::wr_req_t                   wr,
  input  cid_pkg::rd_req_t                   rd,
  output logic signed [cid_pkg::SampleW-1:0] rd_data
);

  logic [cid_pkg::SampleW-1:0] mem [cid_pkg::BufDepth];
  logic [cid_pkg::SampleW-1:0] raw;
  logic                        hit;
  logic [cid_pkg::SizeW-1:0]   fill;
  logic [cid_pkg::SizeW-1:0]   wr_top;

  // Writes only ever land at the pointer, which moves up from zero or
  // drops back, so written entries always form a prefix [0, fill).
  assign wr_top = {1'b0, wr.addr} + cid_pkg::SizeW'(1);

  always_ff @(posedge clk) begin
    if (rst) begin
      fill <= '0;
    end else if (wr.en && (wr_top > fill)) begin
      fill <= wr_top;
    end
  end

  // Memory port
  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
    if (rd.en) begin
      raw <= mem[rd.addr];
      hit <= ({1'b0, rd.addr} < fill);
    end
  end

  // Entries beyond the fill mark read as cleared
  assign rd_data = hit ? signed'(raw) : '0;

endmodule

/* src/cid_interp.sv */
module cid_interp (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                start,
  input  logic signed [cid_pkg::SampleW-1:0]  y0,
  input  logic signed [cid_pkg::SampleW-1:0]  y1,
  input  logic signed [cid_pkg::SampleW-1:0]  y2,
  input  logic signed [cid_pkg::SampleW-1:0]  y3,
  input  logic [cid_pkg::FracBits-1:0]        frac,
  output logic                                done,
  output logic signed [cid_pkg::SampleW-1:0]  result
);

  typedef enum logic [3:0] {
    P_IDLE = 4'b0001,
    P_MUL  = 4'b0010,
    P_ADD  = 4'b0100,
    P_FIN  = 4'b1000
  } phase_t;

  localparam logic signed [cid_pkg::ProdW-1:0] Half =
    cid_pkg::ProdW'(1) <<< (cid_pkg::FracBits - 1);
  localparam logic signed [cid_pkg::VW-1:0] VMax =
    cid_pkg::VW'((1 << (cid_pkg::SampleW - 1)) - 1);
  localparam logic signed [cid_pkg::VW-1:0] VMin = -(VMax + cid_pkg::VW'(1));

  phase_t                             phase;
  logic [1:0]                         step;
  logic signed [cid_pkg::TW-1:0]      t;
  logic signed [cid_pkg::TW-1:0]      d1;
  logic signed [cid_pkg::TW-1:0]      d2;
  logic signed [cid_pkg::ProdW-1:0]   prod;

  logic signed [cid_pkg::TW-1:0]      e0, e1, e2, e3, e12;
  logic signed [cid_pkg::TW-1:0]      d3_c, d2_c, d1_c;
  logic signed [cid_pkg::FracBits:0]  fs;
  logic signed [cid_pkg::ProdW-1:0]   rounded;
  logic signed [cid_pkg::TW-1:0]      dsel;
  logic signed [cid_pkg::TW-1:0]      tr;
  logic signed [cid_pkg::VW-1:0]      v;

  // Doubled Catmull-Rom coefficients
  always_comb begin
    e0   = cid_pkg::TW'(y0);
    e1   = cid_pkg::TW'(y1);
    e2   = cid_pkg::TW'(y2);
    e3   = cid_pkg::TW'(y3);
    e12  = e1 - e2;
    d3_c = (e3 - e0) + e12 + (e12 <<< 1);
    d2_c = (e0 <<< 1) - ((e1 <<< 2) + e1) + (e2 <<< 2) - e3;
    d1_c = e2 - e0;
  end

  // Round-to-nearest rescale and coefficient add
  always_comb begin
    fs      = {1'b0, frac};
    rounded = (prod + Half) >>> cid_pkg::FracBits;
    unique case (step)
      2'd0:    dsel = d2;
      2'd1:    dsel = d1;
      default: dsel = '0;
    endcase
    tr = (t + cid_pkg::TW'(1)) >>> 1;
    v  = cid_pkg::VW'(y1) + cid_pkg::VW'(tr);
  end

  // Sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= P_IDLE;
      done  <= 1'b0;
      step  <= '0;
    end else begin
      done <= 1'b0;
      unique case (phase)
        P_IDLE: begin
          if (start) begin
            step  <= '0;
            phase <= P_MUL;
          end
        end
        P_MUL: begin
          phase <= P_ADD;
        end
        P_ADD: begin
          step  <= step + 2'd1;
          phase <= (step == 2'd2) ? P_FIN : P_MUL;
        end
        P_FIN: begin
          done  <= 1'b1;
          phase <= P_IDLE;
        end
        default: phase <= P_IDLE;
      endcase
    end
  end

  // Horner datapath; inputs stay steady for the whole evaluation
  always_ff @(posedge clk) begin
    unique case (phase)
      P_IDLE: begin
        if (start) begin
          t  <= d3_c;
          d2 <= d2_c;
          d1 <= d1_c;
        end
      end
      P_MUL: prod <= t * fs;
      P_ADD: t <= cid_pkg::TW'(rounded) + dsel;
      P_FIN: begin
        if (v > VMax) begin
          result <= VMax[cid_pkg::SampleW-1:0];
        end else if (v < VMin) begin
          result <= VMin[cid_pkg::SampleW-1:0];
        end else begin
          result <= v[cid_pkg::SampleW-1:0];
        end
      end
      default: ;
    endcase
  end

endmodule

/* src/cubic_interpolated_delay_line_top.sv */
// Fractional delay line on a 524288 x 24-bit ring with Catmull-Rom cubic
// read. An item is taken when start is high and busy is low. A write item
// (req_type 0) stores write_sample at the write pointer unless freeze is set,
// and busy stays low. A read item (req_type 1) runs from accept to its result
// through the one-bit-per-cycle remainder unit that folds the position into
// the active size, four back-to-back reads on the store's single read port,
// and Horner evaluation through one multiplier.
// The result shows on read_sample for exactly one cycle with read_valid high
// and must be captured then; nothing can hold it off. Writing active_size
// while idle reduces the write pointer through the same remainder unit,
// holding busy until the remainder is back. Entries never written since
// reset read as zero; no clearing pass is needed after reset.
module cubic_interpolated_delay_line_top (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 start,
  output logic                                 busy,
  input  logic                                 req_type,
  input  logic signed [cid_pkg::SampleW-1:0]   write_sample,
  input  logic signed [cid_pkg::PosW-1:0]      read_position,
  output logic                                 read_valid,
  output logic signed [cid_pkg::SampleW-1:0]   read_sample,
  input  logic                                 cfg_wr_en,
  input  logic                                 cfg_index,
  input  logic [cid_pkg::SizeW-1:0]            cfg_wdata
);

  typedef enum logic [4:0] {
    S_IDLE   = 5'b00001,
    S_PMOD   = 5'b00010,
    S_QMOD   = 5'b00100,
    S_FETCH  = 5'b01000,
    S_INTERP = 5'b10000
  } state_t;

  state_t                              state;
  logic [cid_pkg::SizeW-1:0]           active_size;
  logic                                freeze;
  logic [cid_pkg::AddrW-1:0]           ptr;
  logic [cid_pkg::AddrW-1:0]           i1;
  logic                                neg;
  logic [cid_pkg::FracBits-1:0]        frac;
  logic [2:0]                          fcnt;
  logic signed [cid_pkg::SampleW-1:0]  y [4];

  logic                                accept;
  logic                                size_wr;
  logic [cid_pkg::SizeW-1:0]           size_clamped;
  logic [cid_pkg::IntW-1:0]            ip;
  logic [cid_pkg::IntW-1:0]            mag;
  logic [cid_pkg::SizeW-1:0]           ptr_inc;
  logic [cid_pkg::AddrW-1:0]           ptr_next;
  logic [cid_pkg::AddrW-1:0]           i1_next;
  logic [cid_pkg::SizeW-1:0]           i1_w;
  logic [cid_pkg::SizeW-1:0]           nb_addr;

  cid_pkg::div_req_t                   div_req;
  logic                                div_done;
  logic [cid_pkg::AddrW-1:0]           div_rem;
  cid_pkg::wr_req_t                    wr_req;
  cid_pkg::rd_req_t                    rd_req;
  logic signed [cid_pkg::SampleW-1:0]  rd_data;
  logic                                interp_start;

  // Handshake
  assign size_wr = cfg_wr_en && (cfg_index == cid_pkg::RegActiveSize);
  assign busy    = (state != S_IDLE) || size_wr;
  assign accept  = start && !busy;

  // Active size clamp
  always_comb begin
    if (cfg_wdata < cid_pkg::SizeW'(cid_pkg::MinSize)) begin
      size_clamped = cid_pkg::SizeW'(cid_pkg::MinSize);
    end else if (cfg_wdata > cid_pkg::SizeW'(cid_pkg::BufDepth)) begin
      size_clamped = cid_pkg::SizeW'(cid_pkg::BufDepth);
    end else begin
      size_clamped = cfg_wdata;
    end
  end

  // Integer part of the position; negative values fold via their magnitude
  assign ip  = read_position[cid_pkg::PosW-1:cid_pkg::FracBits];
  assign mag = ~ip + cid_pkg::IntW'(1);

  // Pointer advance
  always_comb begin
    ptr_inc  = {1'b0, ptr} + cid_pkg::SizeW'(1);
    ptr_next = (ptr_inc >= active_size) ? '0 : ptr_inc[cid_pkg::AddrW-1:0];
  end

  // Floor modulo from the remainder
  always_comb begin
    if (neg && (div_rem != '0)) begin
      i1_next = cid_pkg::AddrW'(active_size - {1'b0, div_rem});
    end else begin
      i1_next = div_rem;
    end
  end

  // Remainder unit requests
  always_comb begin
    div_req = '0;
    if (size_wr && (state == S_IDLE)) begin
      div_req.start    = 1'b1;
      div_req.dividend = cid_pkg::DivW'(ptr);
      div_req.divisor  = size_clamped;
    end else if (accept && (req_type == cid_pkg::ReqRead)) begin
      div_req.start    = 1'b1;
      div_req.dividend = ip[cid_pkg::IntW-1] ? mag : ip;
      div_req.divisor  = active_size;
    end
  end

  // Neighbor addresses: i1-1, i1, i1+1, i1+2, all wrapped to the ring
  always_comb begin
    i1_w = {1'b0, i1};
    unique case (fcnt[1:0])
      2'd0: nb_addr = (i1 == '0) ? active_size - cid_pkg::SizeW'(1)
                                 : i1_w - cid_pkg::SizeW'(1);
      2'd1: nb_addr = i1_w;
      2'd2: nb_addr = (i1_w + cid_pkg::SizeW'(1) >= active_size) ? '0
                                 : i1_w + cid_pkg::SizeW'(1);
      default: nb_addr = (i1_w + cid_pkg::SizeW'(2) >= active_size)
                                 ? i1_w + cid_pkg::SizeW'(2) - active_size
                                 : i1_w + cid_pkg::SizeW'(2);
    endcase
  end

  // Store ports
  always_comb begin
    wr_req.en   = accept && (req_type == cid_pkg::ReqWrite) && !freeze;
    wr_req.addr = ptr;
    wr_req.data = write_sample;
    rd_req.en   = (state == S_FETCH) && (fcnt < 3'd4);
    rd_req.addr = nb_addr[cid_pkg::AddrW-1:0];
  end

  assign interp_start = (state == S_FETCH) && (fcnt == 3'd5);

  // Control
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      active_size <= cid_pkg::SizeW'(cid_pkg::BufDepth);
      freeze      <= 1'b0;
      ptr         <= '0;
      fcnt        <= '0;
    end else begin
      if (cfg_wr_en) begin
        unique case (cfg_index)
          cid_pkg::RegActiveSize: active_size <= size_clamped;
          cid_pkg::RegFreeze:     freeze      <= cfg_wdata[0];
          default: ;
        endcase
      end
      unique case (state)
        S_IDLE: begin
          if (size_wr) begin
            state <= S_PMOD;
          end else if (accept) begin
            if (req_type == cid_pkg::ReqRead) begin
              state <= S_QMOD;
            end else if (!freeze) begin
              ptr <= ptr_next;
            end
          end
        end
        S_PMOD: begin
          if (div_done) begin
            ptr   <= div_rem;
            state <= S_IDLE;
          end
        end
        S_QMOD: begin
          if (div_done) begin
            fcnt  <= '0;
            state <= S_FETCH;
          end
        end
        S_FETCH: begin
          fcnt <= fcnt + 3'd1;
          if (fcnt == 3'd5) begin
            state <= S_INTERP;
          end
        end
        S_INTERP: begin
          if (read_valid) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // Read item payload
  always_ff @(posedge clk) begin
    if (accept) begin
      neg  <= ip[cid_pkg::IntW-1];
      frac <= read_position[cid_pkg::FracBits-1:0];
    end
    if ((state == S_QMOD) && div_done) begin
      i1 <= i1_next;
    end
    if ((state == S_FETCH) && (fcnt != 3'd0) && (fcnt < 3'd5)) begin
      y[2'(fcnt - 3'd1)] <= rd_data;
    end
  end

  cid_mod_unit u_mod (
    .clk  (clk),
    .rst  (rst),
    .req  (div_req),
    .done (div_done),
    .rem  (div_rem)
  );

  cid_store u_store (
    .clk     (clk),
    .rst     (rst),
    .wr      (wr_req),
    .rd      (rd_req),
    .rd_data (rd_data)
  );

  cid_interp u_interp (
    .clk    (clk),
    .rst    (rst),
    .start  (interp_start),
    .y0     (y[0]),
    .y1     (y[1]),
    .y2     (y[2]),
    .y3     (y[3]),
    .frac   (frac),
    .done   (read_valid),
    .result (read_sample)
  );

endmodule
